### hdl/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // Default depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Padding character '='.
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Group phase codes: bytes already consumed in the current 3-byte group.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  // Permuted alphabet, first character in the top byte.
  localparam logic [511:0] ALPHA_STR =
    "RBCYEFGHIJKLMN0PQASTUVWXD4ZbcdefghijklmnopqrstuvwxyzO123a56789+/";

  // One input transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] out_char;
    logic       end_of_text;
  } out_t;

  // One character slot of a job: a 6-bit code or a pad.
  typedef struct packed {
    logic       pad;
    logic [5:0] code;
  } sym_t;

  // Work for one accepted byte: up to four characters.
  typedef struct packed {
    logic            fin;
    logic [1:0]      last_idx;
    sym_t [3:0]      sym;
  } job_t;

  // Map a 6-bit code to its ASCII character.
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    logic [5:0] rev;
    rev = 6'd63 - v;
    return ALPHA_STR[{rev, 3'b000} +: 8];
  endfunction

  // Turn a character slot into the byte that goes out.
  function automatic logic [7:0] sym_char(input sym_t s);
    return s.pad ? PAD_CHAR : alpha_char(s.code);
  endfunction

endpackage

`default_nettype wire

### hdl/base64_custom_alphabet_encoder.sv
// Top level of the streaming base64 encoder with a permuted alphabet.
//
//   Channel   Direction  Handshake           Payload
//   in_*      input      in_valid/in_stall   in_t  {data_byte, is_final}
//   out_*     output     out_valid/out_stall out_t {out_char, end_of_text}
//
// One byte is taken per cycle while the job queue has room; characters leave
// at one per cycle from the back part while the output is not stalled.
// A byte's first character passes through the job queue, the job register
// and the output register before it appears.
// Synchronous active-low reset clears phase, queue and output valid.
// in_stall rises only when the job queue is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_custom_alphabet_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic push, q_full, pop, q_valid;
  job_t push_job, q_job;

  // Byte intake and classification.
  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // Job queue.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // Character output.
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### hdl/b64e_front.sv
// Front part: accepts bytes, tracks the group phase and builds character jobs.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      push,
  output job_t      push_job,
  input  wire logic q_full
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       fin;

  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;
  assign b        = in_data.data_byte;
  assign fin      = in_data.is_final;

  // Split the byte against the carried bits and pick the characters.
  always_comb begin
    push_job     = '0;
    push_job.fin = fin;
    phase_nxt    = PH_START;
    carry_nxt    = 4'd0;
    case (phase_r)
      PH_ONE: begin
        push_job.sym[0].code = {carry_r[1:0], b[7:4]};
        if (fin) begin
          push_job.sym[1].code = {b[3:0], 2'b00};
          push_job.sym[2].pad  = 1'b1;
          push_job.last_idx    = 2'd2;
        end else begin
          push_job.last_idx = 2'd0;
          phase_nxt         = PH_TWO;
          carry_nxt         = b[3:0];
        end
      end
      PH_TWO: begin
        push_job.sym[0].code = {carry_r, b[7:6]};
        push_job.sym[1].code = b[5:0];
        push_job.last_idx    = 2'd1;
      end
      default: begin
        push_job.sym[0].code = b[7:2];
        if (fin) begin
          push_job.sym[1].code = {b[1:0], 4'b0000};
          push_job.sym[2].pad  = 1'b1;
          push_job.sym[3].pad  = 1'b1;
          push_job.last_idx    = 2'd3;
        end else begin
          push_job.last_idx = 2'd0;
          phase_nxt         = PH_ONE;
          carry_nxt         = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  // Group state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      carry_r <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  // The phase only counts zero to two.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("group phase left its range");

  // At the start of a group no bits are carried.
  a_carry_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_START |-> carry_r == 4'd0)
    else $error("carry bits left over at group start");

endmodule

`default_nettype wire

### hdl/b64e_queue.sv
// Small job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_job   = mem[rd_r];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Fill count never passes the depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count overflow");

  // A pop only happens when a job is held.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

### hdl/b64e_back.sv
// Back part: walks jobs one character per cycle to out_data_r unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic       have_r;
  logic [1:0] idx_r;
  job_t       job_r;
  logic       out_valid_r;
  out_t       out_data_r;
  logic       out_free, emit, at_end;
  sym_t       cur;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign emit      = have_r & out_free;
  assign at_end    = idx_r == job_r.last_idx;
  assign pop       = q_valid & (~have_r | (emit & at_end));
  assign cur       = job_r.sym[idx_r];
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Job tracking and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        have_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (emit) begin
        have_r <= ~at_end;
        idx_r  <= at_end ? 2'd0 : idx_r + 2'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_data_r.out_char    <= sym_char(cur);
      out_data_r.end_of_text <= job_r.fin & at_end;
    end
  end

  // The character index never runs past the job.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> idx_r <= job_r.last_idx)
    else $error("character index beyond job");

  // With no job held the index sits at zero.
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !have_r |-> idx_r == 2'd0)
    else $error("index not cleared between jobs");

endmodule

`default_nettype wire

### dv/base64_custom_alphabet_encoder_tb.sv
// Testbench for the permuted-alphabet base64 encoder: directed and random messages.
`timescale 1ns / 1ps

module base64_custom_alphabet_encoder_tb;
  import b64e_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_BYTES = 200;

  // Encoding table, first character in the top byte.
  localparam logic [511:0] ENC_TABLE =
    "RBCYEFGHIJKLMN0PQASTUVWXD4ZbcdefghijklmnopqrstuvwxyzO123a56789+/";

  // Receiver backpressure patterns.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_EVERY_THIRD,
    STALL_HEAVY
  } stall_mode_t;

  // One byte waiting to be sent, optionally held until the output drains.
  typedef struct {
    in_t item;
    bit  wait_drain;
  } byte_req_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  byte_req_t pending_bytes[$];
  out_t      exp_chars[$];

  // Predictor state: bytes consumed in the group and the leftover bits.
  logic [1:0] enc_phase = PH_START;
  logic [3:0] enc_carry = '0;

  int          errors      = 0;
  bit          stim_done   = 1'b0;
  bit          in_took     = 1'b0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  int          idle_cycles = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  int          stall_timer = 0;
  int          stall_count = 0;

  base64_custom_alphabet_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Look up the character for a 6-bit code.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    return ENC_TABLE[511 - 8 * int'(v) -: 8];
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic eot);
    out_t c;
    c.out_char    = ch;
    c.end_of_text = eot;
    exp_chars.push_back(c);
  endtask

  // Work out the characters one accepted byte produces and advance the state.
  task automatic encode_byte(input in_t b);
    logic [7:0] d;
    d = b.data_byte;
    case (enc_phase)
      PH_ONE: begin
        push_char(enc_char({enc_carry[1:0], d[7:4]}), 1'b0);
        if (b.is_final) begin
          push_char(enc_char({d[3:0], 2'b00}), 1'b0);
          push_char(PAD_CHAR, 1'b1);
          enc_phase = PH_START;
          enc_carry = '0;
        end else begin
          enc_phase = PH_TWO;
          enc_carry = d[3:0];
        end
      end
      PH_TWO: begin
        push_char(enc_char({enc_carry, d[7:6]}), 1'b0);
        push_char(enc_char(d[5:0]), b.is_final);
        enc_phase = PH_START;
        enc_carry = '0;
      end
      default: begin
        push_char(enc_char(d[7:2]), 1'b0);
        if (b.is_final) begin
          push_char(enc_char({d[1:0], 4'b0000}), 1'b0);
          push_char(PAD_CHAR, 1'b0);
          push_char(PAD_CHAR, 1'b1);
          enc_phase = PH_START;
          enc_carry = '0;
        end else begin
          enc_phase = PH_ONE;
          enc_carry = {2'b00, d[1:0]};
        end
      end
    endcase
  endtask

  task automatic add_byte(input logic [7:0] d, input logic fin, input bit wd);
    byte_req_t r;
    r.item.data_byte = d;
    r.item.is_final  = fin;
    r.wait_drain     = wd;
    pending_bytes.push_back(r);
  endtask

  // Queue a message of random bytes, the last one flagged final.
  task automatic add_message(input int len, input bit wd);
    for (int i = 0; i < len; i++) begin
      add_byte(8'($urandom_range(0, 255)), i == len - 1, wd && i == 0);
    end
  endtask

  // Monitor: check each result transfer, then predict from each input transfer.
  always @(posedge clk) begin
    out_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (exp_chars.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual char %h eot %b",
                   $time, out_data.out_char, out_data.end_of_text);
          errors++;
        end else begin
          want = exp_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch, expected %h, actual %h",
                     $time, want.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.end_of_text !== want.end_of_text) begin
            $display("%0t: end_of_text mismatch, expected %b, actual %b",
                     $time, want.end_of_text, out_data.end_of_text);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        encode_byte(in_data);
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Driver: bursts of bytes with random gaps; holds the payload while stalled.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_bytes.size() == 0) begin
        in_valid  <= 1'b0;
        stim_done <= 1'b1;
      end else if (pending_bytes[0].wait_drain && exp_chars.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_bytes[0].item;
        in_valid <= 1'b1;
        void'(pending_bytes.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: switch between backpressure patterns every so often.
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode  <= stall_mode_t'($urandom_range(0, 3));
      stall_timer <= $urandom_range(20, 150);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    stall_count <= stall_count + 1;
    case (stall_mode)
      STALL_NONE:        out_stall <= 1'b0;
      STALL_COIN:        out_stall <= 1'($urandom_range(0, 1));
      STALL_EVERY_THIRD: out_stall <= (stall_count % 3) == 0;
      default:           out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    int total;
    int len;

    // Final byte in each phase, with all-zero and all-one data.
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b1, 1'b0);
    // A full group followed by a final byte at the start of the next one.
    add_byte(8'hA5, 1'b0, 1'b0);
    add_byte(8'h5A, 1'b0, 1'b0);
    add_byte(8'hC3, 1'b0, 1'b0);
    add_byte(8'h3C, 1'b1, 1'b0);
    add_byte(8'h0F, 1'b0, 1'b0);
    add_byte(8'hF0, 1'b0, 1'b0);
    add_byte(8'h81, 1'b0, 1'b0);
    add_byte(8'h7E, 1'b0, 1'b0);
    add_byte(8'h55, 1'b1, 1'b0);

    // Random messages, mostly short, some long.
    total = 0;
    while (total < RANDOM_BYTES) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      add_message(len, $urandom_range(0, 15) == 0);
      total += len;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(stim_done && exp_chars.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
